// ----- rtl/tcw_pkg.sv -----
// tcw_pkg: shared codes, sequencer states and control structs for the text console writer
// no dependencies; used by every file of the block except tcw_ram
package tcw_pkg;

  localparam int KIND_W   = 2;
  localparam int CODE_W   = 8;
  localparam int ADDR_W   = 11;
  localparam int LOC_W    = 11;
  localparam int CELL_W   = 16;
  localparam int COLOR_W  = 4;
  localparam int ATTR_W   = 2 * COLOR_W;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = COLOR_W;

  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_FORE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BACK = 1'b1;

  localparam logic [COLOR_W-1:0] FORE_RESET = 4'hF;
  localparam logic [COLOR_W-1:0] BACK_RESET = 4'h0;

  localparam logic [CODE_W-1:0] CHAR_BS    = 8'h08;
  localparam logic [CODE_W-1:0] CHAR_TAB   = 8'h09;
  localparam logic [CODE_W-1:0] CHAR_LF    = 8'h0A;
  localparam logic [CODE_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [CODE_W-1:0] CHAR_BLANK = 8'h20;

  localparam logic [CELL_W-1:0] RESET_CELL = 16'h0F20;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COPY,
    ST_FILL,
    ST_DONE
  } seq_state_t;

  // cursor commands from the sequencer
  typedef struct packed {
    logic              advance;
    logic              home;
    logic [CODE_W-1:0] code;
  } cursor_cmd_t;

  // cursor status back to the sequencer
  typedef struct packed {
    logic store;
    logic scroll;
  } cursor_stat_t;

endpackage

// ----- rtl/tcw_in_if.sv -----
// tcw_in_if: request channel of the text console writer (valid, ready, payload)
// depends on tcw_pkg
interface tcw_in_if;
  logic                      valid;
  logic                      ready;
  logic [tcw_pkg::KIND_W-1:0] kind;
  logic [tcw_pkg::CODE_W-1:0] char_code;
  logic [tcw_pkg::ADDR_W-1:0] cell_address;

  modport source (output valid, kind, char_code, cell_address, input ready);
  modport sink (input valid, kind, char_code, cell_address, output ready);
endinterface

// ----- rtl/tcw_out_if.sv -----
// tcw_out_if: result channel of the text console writer (valid, ready, payload)
// depends on tcw_pkg
interface tcw_out_if;
  logic                      valid;
  logic                      ready;
  logic [tcw_pkg::LOC_W-1:0]  cursor_location;
  logic [tcw_pkg::CELL_W-1:0] cell_data;

  modport source (output valid, cursor_location, cell_data, input ready);
  modport sink (input valid, cursor_location, cell_data, output ready);
endinterface

// ----- rtl/tcw_ram.sv -----
// tcw_ram: generic single write port, single read port ram with registered read
// no dependencies
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/tcw_cursor.sv -----
// tcw_cursor: cursor registers and control character decode
// depends on tcw_pkg
module tcw_cursor #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                               clk,
  input  logic                               rst,
  input  tcw_pkg::cursor_cmd_t               cmd,
  output tcw_pkg::cursor_stat_t              stat,
  output logic [$clog2(COLUMNS*ROWS)-1:0]    pos,
  output logic [tcw_pkg::LOC_W-1:0]          location
);

  localparam int CCW = $clog2(COLUMNS);
  localparam int RRW = $clog2(ROWS);
  localparam int CXW = $clog2(COLUMNS + 8);
  localparam int RXW = $clog2(ROWS + 1);
  localparam int AW  = $clog2(COLUMNS * ROWS);
  localparam logic [RRW-1:0] LAST_ROW = RRW'(ROWS - 1);

  logic [CCW-1:0] col;
  logic [RRW-1:0] row;
  logic [CCW-1:0] col_next;
  logic [RRW-1:0] row_next;
  logic [CXW-1:0] c_ext;
  logic [CXW-1:0] c_n;
  logic [RXW-1:0] r_n;
  logic [31:0]    pos_wide;

  always_comb begin
    c_ext = CXW'(col);
    c_n   = c_ext;
    r_n   = RXW'(row);
    stat.store = 1'b0;
    if (cmd.code == tcw_pkg::CHAR_BS) begin
      if (col != '0) begin
        c_n = c_ext - CXW'(1);
      end
    end else if (cmd.code == tcw_pkg::CHAR_TAB) begin
      c_n = (c_ext + CXW'(8)) & ~CXW'(7);
    end else if (cmd.code == tcw_pkg::CHAR_CR) begin
      c_n = '0;
    end else if (cmd.code == tcw_pkg::CHAR_LF) begin
      c_n = '0;
      r_n = r_n + RXW'(1);
    end else if (cmd.code >= tcw_pkg::CHAR_BLANK) begin
      stat.store = 1'b1;
      c_n = c_ext + CXW'(1);
    end
    // right edge wrap
    if (32'(c_n) >= COLUMNS) begin
      c_n = '0;
      r_n = r_n + RXW'(1);
    end
    stat.scroll = (32'(r_n) == ROWS);
    col_next = CCW'(c_n);
    row_next = stat.scroll ? LAST_ROW : RRW'(r_n);
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.home) begin
      col <= '0;
      row <= '0;
    end else if (cmd.advance) begin
      col <= col_next;
      row <= row_next;
    end
  end

  assign pos_wide = 32'(row) * COLUMNS + 32'(col);
  assign pos      = AW'(pos_wide);
  assign location = tcw_pkg::LOC_W'(pos_wide);

endmodule

// ----- rtl/text_console_char_writer.sv -----
// text_console_char_writer: 80x25 text console engine, top level with the sweep sequencer
// depends on tcw_pkg, tcw_in_if, tcw_out_if, tcw_ram, tcw_cursor
//
// usage: the request channel carries one transaction per item (kind, char_code,
// cell_address); each item gives exactly one transaction on the result channel with the
// cursor location after the item and, for a cell read, the cell contents.
// colour registers are written through wr_en / wr_index / wr_data (index 0 foreground,
// index 1 background); the user writes them only while idle, not enforced by the block.
// a character write with no scroll, a cell read or an unused kind goes to ST_DONE, where
// the result is loaded into the output register once it is free; then the request channel
// becomes ready again. a clear screen sweeps every cell once.
// a character that moves the cursor past the last row triggers a scroll: one cell a
// cycle through the shared address counter and the single write port of the screen
// ram, copying each row up (ST_COPY) and then blanking the bottom row (ST_FILL).
// reset: the cursor goes home, colours return to white on black, and a clearing pass
// writes the reset blank into all ROWS*COLUMNS cells before the request channel becomes
// ready; colour writes are taken during the pass.
// a stalled receiver holds the result register; one further item may be accepted and
// processed, then the block waits with its finished result until the register drains.
module text_console_char_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                             clk,
  input  logic                             rst,
  tcw_in_if.sink                           request,
  tcw_out_if.source                        result,
  input  logic                             wr_en,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]    wr_index,
  input  logic [tcw_pkg::CFG_DAT_W-1:0]    wr_data
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam logic [AW-1:0] LAST_CELL  = AW'(CELLS - 1);
  localparam logic [AW-1:0] COPY_END   = AW'(CELLS - COLUMNS);
  localparam logic [AW-1:0] ROW_STRIDE = AW'(COLUMNS);

  // colour registers
  logic [tcw_pkg::COLOR_W-1:0] fore;
  logic [tcw_pkg::COLOR_W-1:0] back;
  logic [tcw_pkg::ATTR_W-1:0]  attr;

  always_ff @(posedge clk) begin
    if (rst) begin
      fore <= tcw_pkg::FORE_RESET;
      back <= tcw_pkg::BACK_RESET;
    end else if (wr_en) begin
      case (wr_index)
        tcw_pkg::REG_FORE: fore <= wr_data;
        tcw_pkg::REG_BACK: back <= wr_data;
        default: ;
      endcase
    end
  end

  assign attr = {back, fore};

  // sequencer registers
  tcw_pkg::seq_state_t state, state_next;
  logic [AW-1:0] cnt, cnt_next;      // shared sweep counter
  logic          init, init_next;    // reset clearing pass in progress
  logic          is_read, is_read_next;
  logic          rd_ok, rd_ok_next;

  // result register
  logic                       out_valid;
  logic [tcw_pkg::LOC_W-1:0]  out_loc;
  logic [tcw_pkg::CELL_W-1:0] out_data;
  logic                       out_load;

  // ram and cursor hookup
  logic                       ram_we, ram_re;
  logic [AW-1:0]              ram_waddr, ram_raddr;
  logic [tcw_pkg::CELL_W-1:0] ram_wdata, ram_rdata;
  logic [tcw_pkg::CELL_W-1:0] fill_cell;

  tcw_pkg::cursor_cmd_t  cur_cmd;
  tcw_pkg::cursor_stat_t cur_stat;
  logic [AW-1:0]              cur_pos;
  logic [tcw_pkg::LOC_W-1:0]  cur_loc;

  logic accept;

  assign request.ready = (state == tcw_pkg::ST_IDLE);
  assign accept        = request.valid && request.ready;
  assign fill_cell     = init ? tcw_pkg::RESET_CELL : {attr, tcw_pkg::CHAR_BLANK};

  tcw_cursor #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_cursor (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cur_cmd),
    .stat     (cur_stat),
    .pos      (cur_pos),
    .location (cur_loc)
  );

  tcw_ram #(
    .WIDTH (tcw_pkg::CELL_W),
    .DEPTH (CELLS)
  ) u_screen (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= tcw_pkg::ST_FILL;
      cnt     <= '0;
      init    <= 1'b1;
      is_read <= 1'b0;
      rd_ok   <= 1'b0;
    end else begin
      state   <= state_next;
      cnt     <= cnt_next;
      init    <= init_next;
      is_read <= is_read_next;
      rd_ok   <= rd_ok_next;
    end
  end

  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    init_next    = init;
    is_read_next = is_read;
    rd_ok_next   = rd_ok;
    cur_cmd.advance = 1'b0;
    cur_cmd.home    = 1'b0;
    cur_cmd.code    = request.char_code;
    ram_we    = 1'b0;
    ram_waddr = cur_pos;
    ram_wdata = {attr, request.char_code};
    ram_re    = 1'b0;
    ram_raddr = AW'(request.cell_address);
    out_load  = 1'b0;

    case (state)
      tcw_pkg::ST_IDLE: begin
        if (accept) begin
          is_read_next = (request.kind == tcw_pkg::KIND_READ);
          rd_ok_next   = (32'(request.cell_address) < CELLS);
          state_next   = tcw_pkg::ST_DONE;
          case (request.kind)
            tcw_pkg::KIND_WRITE: begin
              // printable byte lands at the old cursor before any scroll
              cur_cmd.advance = 1'b1;
              ram_we          = cur_stat.store;
              if (cur_stat.scroll) begin
                cnt_next   = '0;
                state_next = tcw_pkg::ST_COPY;
              end
            end
            tcw_pkg::KIND_CLEAR: begin
              cur_cmd.home = 1'b1;
              cnt_next     = '0;
              state_next   = tcw_pkg::ST_FILL;
            end
            tcw_pkg::KIND_READ: begin
              ram_re = 1'b1;
            end
            default: ;
          endcase
        end
      end
      tcw_pkg::ST_COPY: begin
        // read one row ahead, write back the cell read in the previous cycle
        ram_raddr = cnt + ROW_STRIDE;
        ram_re    = (cnt != COPY_END);
        ram_waddr = cnt - AW'(1);
        ram_wdata = ram_rdata;
        ram_we    = (cnt != '0);
        if (cnt == COPY_END) begin
          state_next = tcw_pkg::ST_FILL;
        end else begin
          cnt_next = cnt + AW'(1);
        end
      end
      tcw_pkg::ST_FILL: begin
        ram_waddr = cnt;
        ram_wdata = fill_cell;
        ram_we    = 1'b1;
        if (cnt == LAST_CELL) begin
          state_next = init ? tcw_pkg::ST_IDLE : tcw_pkg::ST_DONE;
          init_next  = 1'b0;
        end else begin
          cnt_next = cnt + AW'(1);
        end
      end
      tcw_pkg::ST_DONE: begin
        // hand the result over once the output register is free
        if (!out_valid || result.ready) begin
          out_load   = 1'b1;
          state_next = tcw_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = tcw_pkg::ST_IDLE;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_loc  <= cur_loc;
      out_data <= (is_read && rd_ok) ? ram_rdata : '0;
    end
  end

  assign result.valid           = out_valid;
  assign result.cursor_location = out_loc;
  assign result.cell_data       = out_data;

`ifndef ASSERT_OFF
  // one item at a time: an accepted transaction always closes the request side
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !request.ready)
    else $error("request ready right after an accepted transaction");

  // the cursor never points outside the screen
  a_cursor_on_screen: assert property (@(posedge clk) disable iff (rst)
    32'(cur_pos) < CELLS)
    else $error("cursor outside the screen");

  // no screen writes while a result is being handed over
  a_no_write_in_done: assert property (@(posedge clk) disable iff (rst)
    (state == tcw_pkg::ST_DONE) |-> !ram_we)
    else $error("screen write while waiting on the result register");

  // a result is loaded only into a free or draining register
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (out_load && out_valid) |-> result.ready)
    else $error("result register overrun");
`endif

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps
// testbench: self-checking bench for text_console_char_writer (80x25 text console)
// depends on tcw_pkg, tcw_in_if, tcw_out_if and the block itself; a built-in predictor
// checks every unpinned result against a shadow screen, cursor and colour set
module testbench;

  // screen geometry as built into the block by default
  localparam int COLUMNS        = 80;
  localparam int ROWS           = 25;
  localparam int CELLS          = COLUMNS * ROWS;
  // a scroll or a clear sweeps every cell once, so this covers the slowest item
  localparam int DRAIN_CYCLES   = CELLS + 16;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int PHASES         = 8;
  localparam int ITEMS_PER_PHASE = 235;

  // the one kind that the block does not use
  localparam logic [tcw_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic [tcw_pkg::KIND_W-1:0] kind;
    logic [tcw_pkg::CODE_W-1:0] code;
    logic [tcw_pkg::ADDR_W-1:0] addr;
  } console_req_t;

  typedef struct packed {
    logic [tcw_pkg::LOC_W-1:0]  loc;
    logic [tcw_pkg::CELL_W-1:0] data;
  } console_resp_t;

  // one row of the directed table: pinned rows carry their expected result
  typedef struct packed {
    console_req_t  req;
    logic          pinned;
    console_resp_t resp;
  } directed_row_t;

  logic clk;
  logic rst;
  logic wr_en;
  logic [tcw_pkg::CFG_IDX_W-1:0] wr_index;
  logic [tcw_pkg::CFG_DAT_W-1:0] wr_data;

  tcw_in_if  request_ch();
  tcw_out_if result_ch();

  text_console_char_writer dut (
    .clk      (clk),
    .rst      (rst),
    .request  (request_ch),
    .result   (result_ch),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  // expectation for the transaction being offered, driven alongside the payload
  logic          offer_pinned;
  console_resp_t offer_resp;

  // shadow of the block: screen, cursor and colour registers
  logic [tcw_pkg::CELL_W-1:0]  shadow_cells [CELLS];
  logic [6:0]                  shadow_col;
  logic [4:0]                  shadow_row;
  logic [tcw_pkg::COLOR_W-1:0] shadow_fore;
  logic [tcw_pkg::COLOR_W-1:0] shadow_back;

  console_resp_t pending_results[$];
  directed_row_t directed_rows[$];

  int error_count;
  int idle_cycles;
  int send_idle_pct;
  int recv_stall_pct;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // known values on every input from time zero, with reset held at the start
  initial begin
    rst                = 1'b1;
    wr_en              = 1'b0;
    wr_index           = tcw_pkg::REG_FORE;
    wr_data            = '0;
    request_ch.valid   = 1'b0;
    request_ch.kind    = tcw_pkg::KIND_WRITE;
    request_ch.char_code = '0;
    request_ch.cell_address = '0;
    result_ch.ready    = 1'b0;
    offer_pinned       = 1'b0;
    offer_resp         = '0;
    send_idle_pct      = 0;
    recv_stall_pct     = 0;
    error_count        = 0;
    shadow_col         = '0;
    shadow_row         = '0;
    shadow_fore        = tcw_pkg::FORE_RESET;
    shadow_back        = tcw_pkg::BACK_RESET;
    for (int i = 0; i < CELLS; i++) shadow_cells[i] = tcw_pkg::RESET_CELL;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
  end

  // blank cell in the current colours, used by scroll and clear
  function automatic logic [tcw_pkg::CELL_W-1:0] blank_in_colour();
    return {shadow_back, shadow_fore, tcw_pkg::CHAR_BLANK};
  endfunction

  // advances the shadow console by one request and works out its result
  task automatic predict_console_step(input console_req_t req, output console_resp_t resp);
    int pos;
    resp.data = '0;
    case (req.kind)
      tcw_pkg::KIND_WRITE: begin
        if (req.code == tcw_pkg::CHAR_BS) begin
          // backspace at column zero leaves the cursor alone
          if (shadow_col != 0) shadow_col = shadow_col - 7'd1;
        end else if (req.code == tcw_pkg::CHAR_TAB) begin
          shadow_col = (shadow_col + 7'd8) & 7'h78;
        end else if (req.code == tcw_pkg::CHAR_CR) begin
          shadow_col = '0;
        end else if (req.code == tcw_pkg::CHAR_LF) begin
          shadow_col = '0;
          shadow_row = shadow_row + 5'd1;
        end else if (req.code >= tcw_pkg::CHAR_BLANK) begin
          pos = int'(shadow_row) * COLUMNS + int'(shadow_col);
          if (pos < CELLS) shadow_cells[pos] = {shadow_back, shadow_fore, req.code};
          shadow_col = shadow_col + 7'd1;
        end
        // wrap at the right edge
        if (shadow_col >= COLUMNS) begin
          shadow_col = '0;
          shadow_row = shadow_row + 5'd1;
        end
        // past the last row: scroll up one row and blank the bottom one
        if (shadow_row >= ROWS) begin
          for (int i = 0; i < CELLS - COLUMNS; i++) shadow_cells[i] = shadow_cells[i + COLUMNS];
          for (int i = CELLS - COLUMNS; i < CELLS; i++) shadow_cells[i] = blank_in_colour();
          shadow_row = 5'(ROWS - 1);
        end
      end
      tcw_pkg::KIND_CLEAR: begin
        for (int i = 0; i < CELLS; i++) shadow_cells[i] = blank_in_colour();
        shadow_col = '0;
        shadow_row = '0;
      end
      tcw_pkg::KIND_READ: begin
        // reads beyond the screen return zero
        if (req.addr < CELLS) resp.data = shadow_cells[req.addr];
      end
      default: begin
        // unused kind: no state change
      end
    endcase
    resp.loc = tcw_pkg::LOC_W'(int'(shadow_row) * COLUMNS + int'(shadow_col));
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // everything is sampled at the clock edge, with all tb inputs driven by nonblocking
  // assignment, so the order of processes within a time step never matters
  always @(posedge clk) begin : observe
    console_req_t  seen_req;
    console_resp_t seen_resp;
    console_resp_t want;
    if (!rst) begin
      // colour writes only happen while the block is idle
      if (wr_en) begin
        if (wr_index == tcw_pkg::REG_FORE) shadow_fore = wr_data;
        else if (wr_index == tcw_pkg::REG_BACK) shadow_back = wr_data;
      end
      // result transaction: compare with the oldest expectation
      if (result_ch.valid && result_ch.ready) begin
        seen_resp.loc  = result_ch.cursor_location;
        seen_resp.data = result_ch.cell_data;
        if (pending_results.size() == 0) begin
          report_mismatch("result with nothing outstanding", 32'(seen_resp), '0);
        end else begin
          want = pending_results.pop_front();
          if (seen_resp.loc !== want.loc)
            report_mismatch("cursor_location", 32'(seen_resp.loc), 32'(want.loc));
          if (seen_resp.data !== want.data)
            report_mismatch("cell_data", 32'(seen_resp.data), 32'(want.data));
        end
      end
      // request transaction: run the predictor, pinned rows override its answer
      if (request_ch.valid && request_ch.ready) begin
        seen_req.kind = request_ch.kind;
        seen_req.code = request_ch.char_code;
        seen_req.addr = request_ch.cell_address;
        predict_console_step(seen_req, want);
        if (offer_pinned) want = offer_resp;
        pending_results.push_back(want);
      end
    end
  end

  // receiver: ready held high or dropped at random, per the current idling mode
  always @(posedge clk) begin
    if (recv_stall_pct == 0) result_ch.ready <= 1'b1;
    else result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog: cycles without any transaction on either channel
  always @(posedge clk) begin
    if (rst || (request_ch.valid && request_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", idle_cycles);
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // offers one request, with a random run of idle cycles first; returns at the edge that
  // accepted it, with valid still high so the next request can follow straight on
  task automatic send_item(input console_req_t req, input logic pinned,
                           input console_resp_t pinned_resp);
    int gap;
    gap = 0;
    while (send_idle_pct != 0 && gap < 16 && $urandom_range(99) < send_idle_pct) begin
      request_ch.valid <= 1'b0;
      @(posedge clk);
      gap++;
    end
    request_ch.valid        <= 1'b1;
    request_ch.kind         <= req.kind;
    request_ch.char_code    <= req.code;
    request_ch.cell_address <= req.addr;
    offer_pinned            <= pinned;
    offer_resp              <= pinned_resp;
    @(posedge clk);
    while (!request_ch.ready) @(posedge clk);
  endtask

  // drains the block, lets any sweep finish, then writes both colour registers
  task automatic set_colours(input logic [tcw_pkg::COLOR_W-1:0] fore,
                             input logic [tcw_pkg::COLOR_W-1:0] back);
    request_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    wr_en    <= 1'b1;
    wr_index <= tcw_pkg::REG_FORE;
    wr_data  <= fore;
    @(posedge clk);
    wr_index <= tcw_pkg::REG_BACK;
    wr_data  <= back;
    @(posedge clk);
    wr_en    <= 1'b0;
  endtask

  task automatic add_row(input logic [tcw_pkg::KIND_W-1:0] kind,
                         input logic [tcw_pkg::CODE_W-1:0] code,
                         input logic [tcw_pkg::ADDR_W-1:0] addr, input logic pinned,
                         input logic [tcw_pkg::LOC_W-1:0] loc,
                         input logic [tcw_pkg::CELL_W-1:0] data);
    directed_row_t row;
    row.req.kind  = kind;
    row.req.code  = code;
    row.req.addr  = addr;
    row.pinned    = pinned;
    row.resp.loc  = loc;
    row.resp.data = data;
    directed_rows.push_back(row);
  endtask

  // random request: mostly printable text, line control, reads, rare clears, unused kinds
  function automatic console_req_t random_request();
    console_req_t req;
    int pick;
    int sub;
    pick     = $urandom_range(0, 999);
    sub      = $urandom_range(0, 99);
    req.code = 8'($urandom_range(0, 255));
    req.addr = 11'($urandom_range(0, 2047));
    if (pick < 10) begin
      req.kind = tcw_pkg::KIND_CLEAR;
    end else if (pick < 20) begin
      req.kind = KIND_UNUSED;
    end else if (pick < 110) begin
      req.kind = tcw_pkg::KIND_READ;
      // bias towards the bottom rows, where text lands once the screen scrolls
      if (sub < 40) req.addr = 11'($urandom_range(CELLS - 2 * COLUMNS, 2047));
    end else begin
      req.kind = tcw_pkg::KIND_WRITE;
      if (sub < 5) req.code = tcw_pkg::CHAR_LF;
      else if (sub < 9) req.code = tcw_pkg::CHAR_CR;
      else if (sub < 14) req.code = tcw_pkg::CHAR_TAB;
      else if (sub < 20) req.code = tcw_pkg::CHAR_BS;
      else if (sub < 24) req.code = 8'($urandom_range(0, 31));
      else req.code = 8'($urandom_range(32, 255));
    end
    return req;
  endfunction

  initial begin : stimulus
    directed_row_t row;
    console_req_t  req;
    logic [tcw_pkg::COLOR_W-1:0] fore;
    logic [tcw_pkg::COLOR_W-1:0] back;

    // directed table; the pinned rows up to the backspace are read off the reset state
    add_row(tcw_pkg::KIND_READ,  8'h00, 11'd0,    1'b1, 11'd0, tcw_pkg::RESET_CELL);
    add_row(tcw_pkg::KIND_READ,  8'hFF, 11'd1999, 1'b1, 11'd0, tcw_pkg::RESET_CELL);
    add_row(tcw_pkg::KIND_READ,  8'h00, 11'd2047, 1'b1, 11'd0, 16'h0000); // beyond the screen
    add_row(KIND_UNUSED,         8'hFF, 11'h7FF,  1'b1, 11'd0, 16'h0000);
    // backspace at column zero
    add_row(tcw_pkg::KIND_WRITE, tcw_pkg::CHAR_BS, 11'd0, 1'b1, 11'd0, 16'h0000);
    add_row(tcw_pkg::KIND_WRITE, 8'h41,  11'd0,    1'b0, '0, '0);
    add_row(tcw_pkg::KIND_READ,  8'h00,  11'd0,    1'b0, '0, '0);
    add_row(tcw_pkg::KIND_WRITE, 8'hFF,  11'd0,    1'b0, '0, '0);
    add_row(tcw_pkg::KIND_WRITE, tcw_pkg::CHAR_BLANK, 11'd0, 1'b0, '0, '0);
    // control bytes with no effect, then 8'h7F, stored like a printable byte
    add_row(tcw_pkg::KIND_WRITE, 8'h00,  11'd0,    1'b0, '0, '0);
    add_row(tcw_pkg::KIND_WRITE, 8'h1F,  11'd0,    1'b0, '0, '0);
    add_row(tcw_pkg::KIND_WRITE, 8'h7F,  11'd0,    1'b0, '0, '0);
    add_row(tcw_pkg::KIND_WRITE, tcw_pkg::CHAR_BS,  11'd0, 1'b0, '0, '0);
    add_row(tcw_pkg::KIND_WRITE, tcw_pkg::CHAR_TAB, 11'd0, 1'b0, '0, '0);
    add_row(tcw_pkg::KIND_WRITE, tcw_pkg::CHAR_TAB, 11'd0, 1'b0, '0, '0);
    add_row(tcw_pkg::KIND_WRITE, tcw_pkg::CHAR_CR,  11'd0, 1'b0, '0, '0);
    add_row(tcw_pkg::KIND_WRITE, tcw_pkg::CHAR_LF,  11'd0, 1'b0, '0, '0);
    add_row(tcw_pkg::KIND_WRITE, 8'h80,  11'd0,    1'b0, '0, '0);
    add_row(tcw_pkg::KIND_READ,  8'h00,  11'd80,   1'b0, '0, '0);
    add_row(tcw_pkg::KIND_READ,  8'h00,  11'd2,    1'b0, '0, '0);
    add_row(tcw_pkg::KIND_CLEAR, 8'h55,  11'h2AA,  1'b0, '0, '0);
    add_row(tcw_pkg::KIND_READ,  8'h00,  11'd0,    1'b0, '0, '0);
    // beyond, after a clear
    add_row(tcw_pkg::KIND_READ,  8'h00,  11'd2000, 1'b1, 11'd0, 16'h0000);
    add_row(tcw_pkg::KIND_WRITE, tcw_pkg::CHAR_TAB, 11'd0, 1'b0, '0, '0);
    // walk down to the bottom row, mark it, then tab off the right edge to force a scroll
    for (int i = 0; i < ROWS - 1; i++)
      add_row(tcw_pkg::KIND_WRITE, tcw_pkg::CHAR_LF, 11'd0, 1'b0, '0, '0);
    add_row(tcw_pkg::KIND_WRITE, 8'h5A, 11'd0, 1'b0, '0, '0);
    for (int i = 0; i < 10; i++)
      add_row(tcw_pkg::KIND_WRITE, tcw_pkg::CHAR_TAB, 11'd0, 1'b0, '0, '0);
    add_row(tcw_pkg::KIND_READ,  8'h00, 11'd1840, 1'b0, '0, '0);
    add_row(tcw_pkg::KIND_READ,  8'h00, 11'd1920, 1'b0, '0, '0);

    @(negedge rst);
    @(posedge clk);
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      send_item(row.req, row.pinned, row.resp);
    end

    // random phases: a colour setting each, extremes first, idling mode in rotation
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin fore = 4'h0; back = 4'h0; end
        1: begin fore = 4'hF; back = 4'hF; end
        2: begin fore = 4'h0; back = 4'hF; end
        3: begin fore = 4'hF; back = 4'h0; end
        default: begin
          fore = 4'($urandom_range(0, 15));
          back = 4'($urandom_range(0, 15));
        end
      endcase
      set_colours(fore, back);
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
        default: begin send_idle_pct = 38; recv_stall_pct = 38; end
      endcase
      repeat (ITEMS_PER_PHASE) begin
        req = random_request();
        send_item(req, 1'b0, '0);
      end
    end

    // wind down: every result in, then a quiet stretch to catch anything extra
    request_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/tcw_pkg.sv
rtl/tcw_in_if.sv
rtl/tcw_out_if.sv
rtl/tcw_ram.sv
rtl/tcw_cursor.sv
rtl/text_console_char_writer.sv
verif/testbench.sv
